FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the curvature block
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tpc_pkg.sv
// ---------------------------------------------------------------------------
// tpc_pkg
// shared constants and types for the three point curvature pipeline
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpc_pkg;

  localparam int CoordBitsDef    = 20;
  localparam int CurvFracBitsDef = 24;
  localparam int CoordFrac       = 10;
  localparam int MulDigit        = 16;
  localparam int QuotBits        = 64;
  localparam int RootBits        = 32;
  localparam int CurvBits        = 32;

  localparam logic [CurvBits-1:0] PosLimit = 32'h7fff_ffff;
  localparam logic [CurvBits-1:0] NegLimit = 32'h8000_0000;

  typedef struct packed {
    logic detpos;
    logic coll;
  } tpc_flags_t;

endpackage

`default_nettype wire

FILE: design/tpc_mul.sv
// ---------------------------------------------------------------------------
// tpc_mul
// pipelined unsigned multiplier, one 16 bit digit of b per stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_mul #(
  parameter int AW  = 41,
  parameter int BW  = 41,
  parameter int PLW = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [AW-1:0]     a_i,
  input  wire logic [BW-1:0]     b_i,
  input  wire logic [PLW-1:0]    pl_i,
  output logic                   valid_o,
  output logic [AW+BW-1:0]       p_o,
  output logic [PLW-1:0]         pl_o
);
  import tpc_pkg::*;

  localparam int DIG = MulDigit;
  localparam int NST = (BW + DIG - 1) / DIG;
  localparam int BP  = NST * DIG;
  localparam int PW  = AW + BW;

  logic [PW-1:0]  acc_q [NST];
  logic [AW-1:0]  a_q   [NST];
  logic [BP-1:0]  b_q   [NST];
  logic [PLW-1:0] pl_q  [NST];
  logic           v_q   [NST];

  for (genvar k = 0; k < NST; k++) begin : g_st
    logic [PW-1:0]     acc_in;
    logic [AW-1:0]     a_in;
    logic [BP-1:0]     b_in;
    logic [PLW-1:0]    pl_in;
    logic              v_in;
    logic [AW+DIG-1:0] pp;

    if (k == 0) begin : g_first
      assign acc_in = '0;
      assign a_in   = a_i;
      assign b_in   = BP'(b_i);
      assign pl_in  = pl_i;
      assign v_in   = valid_i;
    end else begin : g_next
      assign acc_in = acc_q[k-1];
      assign a_in   = a_q[k-1];
      assign b_in   = b_q[k-1];
      assign pl_in  = pl_q[k-1];
      assign v_in   = v_q[k-1];
    end

    assign pp = a_in * b_in[k*DIG +: DIG];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[k] <= acc_in + (PW'(pp) << (k * DIG));
        a_q[k]   <= a_in;
        b_q[k]   <= b_in;
        pl_q[k]  <= pl_in;
      end
    end
  end

  assign valid_o = v_q[NST-1];
  assign p_o     = acc_q[NST-1];
  assign pl_o    = pl_q[NST-1];

endmodule

`default_nettype wire

FILE: design/tpc_div.sv
// ---------------------------------------------------------------------------
// tpc_div
// restoring divider, one quotient bit per stage, with overflow detect
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_div #(
  parameter int TW  = 100,
  parameter int PW  = 123,
  parameter int PLW = 2
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [TW-1:0]               top_i,
  input  wire logic [tpc_pkg::QuotBits-1:0] low_i,
  input  wire logic [PW-1:0]               den_i,
  input  wire logic [PLW-1:0]              pl_i,
  output logic                             valid_o,
  output logic [tpc_pkg::QuotBits-1:0]     quot_o,
  output logic                             ovf_o,
  output logic [PLW-1:0]                   pl_o
);
  import tpc_pkg::*;

  localparam int QB = QuotBits;
  localparam int CW = (TW > PW) ? TW : PW;

  // overflow check and remainder preset
  logic [PW-1:0]  r0_q;
  logic [QB-1:0]  low0_q;
  logic [PW-1:0]  den0_q;
  logic [PLW-1:0] pl0_q;
  logic           ovf0_q;
  logic           v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r0_q   <= PW'(top_i);
      low0_q <= low_i;
      den0_q <= den_i;
      pl0_q  <= pl_i;
      ovf0_q <= CW'(top_i) >= CW'(den_i);
    end
  end

  logic [PW-1:0]  r_q   [QB];
  logic [QB-1:0]  low_q [QB];
  logic [QB-1:0]  q_q   [QB];
  logic [PW-1:0]  den_q [QB];
  logic [PLW-1:0] pl_q  [QB];
  logic           ovf_q [QB];
  logic           v_q   [QB];

  for (genvar k = 0; k < QB; k++) begin : g_st
    logic [PW-1:0]  r_in;
    logic [QB-1:0]  low_in;
    logic [QB-1:0]  q_in;
    logic [PW-1:0]  den_in;
    logic [PLW-1:0] pl_in;
    logic           ovf_in;
    logic           v_in;
    logic [PW:0]    rsh;
    logic [PW:0]    rsub;
    logic           ge;

    if (k == 0) begin : g_first
      assign r_in   = r0_q;
      assign low_in = low0_q;
      assign q_in   = '0;
      assign den_in = den0_q;
      assign pl_in  = pl0_q;
      assign ovf_in = ovf0_q;
      assign v_in   = v0_q;
    end else begin : g_next
      assign r_in   = r_q[k-1];
      assign low_in = low_q[k-1];
      assign q_in   = q_q[k-1];
      assign den_in = den_q[k-1];
      assign pl_in  = pl_q[k-1];
      assign ovf_in = ovf_q[k-1];
      assign v_in   = v_q[k-1];
    end

    assign rsh  = {r_in, low_in[QB-1]};
    assign rsub = rsh - {1'b0, den_in};
    assign ge   = rsh >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]   <= ge ? rsub[PW-1:0] : rsh[PW-1:0];
        low_q[k] <= low_in << 1;
        q_q[k]   <= {q_in[QB-2:0], ge};
        den_q[k] <= den_in;
        pl_q[k]  <= pl_in;
        ovf_q[k] <= ovf_in;
      end
    end
  end

  assign valid_o = v_q[QB-1];
  assign quot_o  = q_q[QB-1];
  assign ovf_o   = ovf_q[QB-1];
  assign pl_o    = pl_q[QB-1];

endmodule

`default_nettype wire

FILE: design/tpc_sqrt.sv
// ---------------------------------------------------------------------------
// tpc_sqrt
// integer square root, one root bit per stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_sqrt #(
  parameter int PLW = 3
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [tpc_pkg::QuotBits-1:0] val_i,
  input  wire logic [PLW-1:0]               pl_i,
  output logic                              valid_o,
  output logic [tpc_pkg::RootBits-1:0]      root_o,
  output logic [PLW-1:0]                    pl_o
);
  import tpc_pkg::*;

  localparam int RB = RootBits;
  localparam int QB = QuotBits;
  localparam int RW = RB + 2;

  logic [RW-1:0]  rem_q  [RB];
  logic [RB-1:0]  root_q [RB];
  logic [QB-1:0]  val_q  [RB];
  logic [PLW-1:0] pl_q   [RB];
  logic           v_q    [RB];

  for (genvar k = 0; k < RB; k++) begin : g_st
    logic [RW-1:0]  rem_in;
    logic [RB-1:0]  root_in;
    logic [QB-1:0]  val_in;
    logic [PLW-1:0] pl_in;
    logic           v_in;
    logic [RW-1:0]  remsh;
    logic [RW-1:0]  trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = val_i;
      assign pl_in   = pl_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign val_in  = val_q[k-1];
      assign pl_in   = pl_q[k-1];
      assign v_in    = v_q[k-1];
    end

    assign remsh = {rem_in[RW-3:0], val_in[QB-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = remsh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (remsh - trial) : remsh;
        root_q[k] <= {root_in[RB-2:0], ge};
        val_q[k]  <= val_in << 2;
        pl_q[k]   <= pl_in;
      end
    end
  end

  assign valid_o = v_q[RB-1];
  assign root_o  = root_q[RB-1];
  assign pl_o    = pl_q[RB-1];

endmodule

`default_nettype wire

FILE: design/three_point_curvature.sv
// ---------------------------------------------------------------------------
// three_point_curvature
// signed curvature of the circle through three transverse-plane hits
// ---------------------------------------------------------------------------
// usage
//   slave side: one request carries six coordinates (first_x lowest) on
//   s_axis_tdata_i; master side returns the curvature on m_axis_tdata_o with
//   collinear and saturated flags on m_axis_tuser_o
//   throughput: one request per cycle unless the receiver stalls, with any
//   mix of idle cycles on either side; a request passes the difference,
//   product and determinant stages, the chain of multiplier digit stages,
//   the divider preset and 64 quotient-bit stages and the 32 stage square root
//   reset clears every valid bit; no request is in flight afterwards
//   receiver stall: the whole pipeline holds in place, s_axis_tready_o drops
//   and nothing is lost or repeated until m_axis_tready_i rises again
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module three_point_curvature #(
  parameter int COORD_BITS     = tpc_pkg::CoordBitsDef,
  parameter int CURV_FRAC_BITS = tpc_pkg::CurvFracBitsDef
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // first_x, first_y, second_x, second_y, third_x, third_y
  input  wire logic [((6*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata_i,
  output logic                                        m_axis_tvalid_o,
  input  wire logic                                   m_axis_tready_i,
  // curvature
  output logic [tpc_pkg::CurvBits-1:0]                m_axis_tdata_o,
  // collinear, saturated
  output logic [1:0]                                  m_axis_tuser_o
);
  import tpc_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int DB  = 2 * CB + 1;
  localparam int SW  = 2 * CB + 1;
  localparam int SH  = 1 + CoordFrac + CURV_FRAC_BITS;
  localparam int D2W = 2 * DB;
  localparam int PW  = 3 * SW;
  localparam int XW  = D2W + 2 * SH;
  localparam int TW  = XW - QuotBits;
  localparam int FW  = $bits(tpc_flags_t);

  logic en;
  logic out_v_q;

  assign en              = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // stage 1: differences
  logic [CB-1:0]        x1, y1, x2, y2, x3, y3;
  logic signed [CB:0]   ux_q, uy_q, vx_q, vy_q, wx_q, wy_q;
  logic                 v1_q;

  assign x1 = s_axis_tdata_i[0*CB +: CB];
  assign y1 = s_axis_tdata_i[1*CB +: CB];
  assign x2 = s_axis_tdata_i[2*CB +: CB];
  assign y2 = s_axis_tdata_i[3*CB +: CB];
  assign x3 = s_axis_tdata_i[4*CB +: CB];
  assign y3 = s_axis_tdata_i[5*CB +: CB];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ux_q <= $signed({x2[CB-1], x2}) - $signed({x1[CB-1], x1});
      uy_q <= $signed({y2[CB-1], y2}) - $signed({y1[CB-1], y1});
      vx_q <= $signed({x3[CB-1], x3}) - $signed({x1[CB-1], x1});
      vy_q <= $signed({y3[CB-1], y3}) - $signed({y1[CB-1], y1});
      wx_q <= $signed({x3[CB-1], x3}) - $signed({x2[CB-1], x2});
      wy_q <= $signed({y3[CB-1], y3}) - $signed({y2[CB-1], y2});
    end
  end

  // stage 2: cross products and squares
  logic signed [2*CB+1:0] p1_q, p2_q;
  logic signed [2*CB+1:0] sux, suy, svx, svy, swx, swy;
  logic [2*CB-1:0]        squx_q, squy_q, sqvx_q, sqvy_q, sqwx_q, sqwy_q;
  logic                   v2_q;

  assign sux = ux_q * ux_q;
  assign suy = uy_q * uy_q;
  assign svx = vx_q * vx_q;
  assign svy = vy_q * vy_q;
  assign swx = wx_q * wx_q;
  assign swy = wy_q * wy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q   <= ux_q * vy_q;
      p2_q   <= uy_q * vx_q;
      squx_q <= sux[2*CB-1:0];
      squy_q <= suy[2*CB-1:0];
      sqvx_q <= svx[2*CB-1:0];
      sqvy_q <= svy[2*CB-1:0];
      sqwx_q <= swx[2*CB-1:0];
      sqwy_q <= swy[2*CB-1:0];
    end
  end

  // stage 3: determinant and side lengths squared
  logic signed [2*CB+2:0] det, ndet;
  logic [DB-1:0]          dmag_q;
  logic [SW-1:0]          sa_q, sb_q, ss_q;
  tpc_flags_t             fl3_q;
  logic                   v3_q;

  assign det  = $signed({p1_q[2*CB+1], p1_q}) - $signed({p2_q[2*CB+1], p2_q});
  assign ndet = -det;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dmag_q       <= det[2*CB+2] ? ndet[DB-1:0] : det[DB-1:0];
      fl3_q.coll   <= det == '0;
      fl3_q.detpos <= !det[2*CB+2] && (det != '0);
      sa_q         <= {1'b0, squx_q} + {1'b0, squy_q};
      sb_q         <= {1'b0, sqwx_q} + {1'b0, sqwy_q};
      ss_q         <= {1'b0, sqvx_q} + {1'b0, sqvy_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // side product and squared determinant
  logic           va, vb;
  logic [2*SW-1:0] ab;
  logic [SW-1:0]  s_m;
  logic [D2W-1:0] d2;
  logic [FW-1:0]  fl_m;

  tpc_mul #(.AW(SW), .BW(SW), .PLW(SW)) u_mul_ab (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .a_i     (sa_q),
    .b_i     (sb_q),
    .pl_i    (ss_q),
    .valid_o (va),
    .p_o     (ab),
    .pl_o    (s_m)
  );

  tpc_mul #(.AW(DB), .BW(DB), .PLW(FW)) u_mul_dd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .a_i     (dmag_q),
    .b_i     (dmag_q),
    .pl_i    (fl3_q),
    .valid_o (vb),
    .p_o     (d2),
    .pl_o    (fl_m)
  );

  // full product of squared sides
  logic              vp;
  logic [PW-1:0]     prod;
  logic [D2W+FW-1:0] pl_p;
  logic [D2W-1:0]    d2_p;
  logic [FW-1:0]     fl_p;

  tpc_mul #(.AW(2*SW), .BW(SW), .PLW(D2W+FW)) u_mul_abs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (va && vb),
    .a_i     (ab),
    .b_i     (s_m),
    .pl_i    ({d2, fl_m}),
    .valid_o (vp),
    .p_o     (prod),
    .pl_o    (pl_p)
  );

  assign d2_p = pl_p[D2W+FW-1:FW];
  assign fl_p = pl_p[FW-1:0];

  // quotient of numerator squared by side product
  logic [XW-1:0]       xnum;
  logic                vq;
  logic [QuotBits-1:0] quot;
  logic                ovf;
  logic [FW-1:0]       fl_q;

  assign xnum = {d2_p, {(2*SH){1'b0}}};

  tpc_div #(.TW(TW), .PW(PW), .PLW(FW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vp),
    .top_i   (xnum[XW-1:QuotBits]),
    .low_i   (xnum[QuotBits-1:0]),
    .den_i   (prod),
    .pl_i    (fl_p),
    .valid_o (vq),
    .quot_o  (quot),
    .ovf_o   (ovf),
    .pl_o    (fl_q)
  );

  logic                vr;
  logic [RootBits-1:0] root;
  logic [FW:0]         pl_r;
  tpc_flags_t          fl_r;
  logic                ovf_r;

  tpc_sqrt #(.PLW(FW+1)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vq),
    .val_i   (quot),
    .pl_i    ({ovf, fl_q}),
    .valid_o (vr),
    .root_o  (root),
    .pl_o    (pl_r)
  );

  assign ovf_r = pl_r[FW];
  assign fl_r  = pl_r[FW-1:0];

  // clamp, sign and output register
  logic [CurvBits-1:0] lim, mag;
  logic                clamp;
  logic [CurvBits-1:0] curv_q;
  logic                coll_q, sat_q;

  assign lim   = fl_r.detpos ? NegLimit : PosLimit;
  assign clamp = ovf_r || (root > lim);
  assign mag   = clamp ? lim : root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= vr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (fl_r.coll) begin
        curv_q <= '0;
        coll_q <= 1'b1;
        sat_q  <= 1'b0;
      end else begin
        curv_q <= fl_r.detpos ? (~mag + 1'b1) : mag;
        coll_q <= 1'b0;
        sat_q  <= clamp;
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = curv_q;
  assign m_axis_tuser_o  = {sat_q, coll_q};

  `ASSERT_IMPLY(a_coll_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[0],
                (m_axis_tdata_o == '0) && !m_axis_tuser_o[1], "collinear result not zero")
  `ASSERT_IMPLY(a_sat_pos, clk_i, rst_ni,
                m_axis_tvalid_o && m_axis_tuser_o[1] && !m_axis_tdata_o[CurvBits-1],
                m_axis_tdata_o == PosLimit, "positive saturation not at limit")
  `ASSERT_IMPLY(a_sat_neg, clk_i, rst_ni,
                m_axis_tvalid_o && m_axis_tuser_o[1] && m_axis_tdata_o[CurvBits-1],
                m_axis_tdata_o == NegLimit, "negative saturation not at limit")
  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i,
               !s_axis_tready_o || m_axis_tready_i, "pipeline took request while stalled")

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// stream testbench for the three point curvature block
// ---------------------------------------------------------------------------
// hit triplets go in on the slave side; each accepted request is predicted
// with exact wide integer arithmetic and queued. Results on the master side
// are compared in order. Directed corner cases (collinear points, coincident
// points, coordinate extremes, saturation of both signs) come first. Random
// triplets follow: clustered, spread, collinear and coincident, with
// sender gaps and receiver stalls in several phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int CoordBits = tpc_pkg::CoordBitsDef;
  localparam int CurvFrac  = tpc_pkg::CurvFracBitsDef;
  localparam int DataBits  = ((6*CoordBits+7)/8)*8;
  localparam int CurvBits  = tpc_pkg::CurvBits;
  localparam int NumShift  = 1 + tpc_pkg::CoordFrac + CurvFrac;
  localparam int CollBit   = 0;
  localparam int SatBit    = 1;
  localparam int Latency   = 107;
  localparam int PhaseLen  = 210;
  localparam longint CoordMax = (64'sd1 <<< (CoordBits-1)) - 1;
  localparam longint CoordMin = -(64'sd1 <<< (CoordBits-1));

  typedef struct {
    logic [CurvBits-1:0] curvature;
    logic                collinear;
    logic                saturated;
  } curv_res_t;

  function automatic curv_res_t menger_curvature(logic [DataBits-1:0] hits);
    longint x1, y1, x2, y2, x3, y3, det, dmag, sa, sb, sc;
    logic [255:0] prod, num2, cand, trial;
    logic [63:0]  q, lim;
    curv_res_t    r;
    x1 = $signed(hits[0*CoordBits +: CoordBits]);
    y1 = $signed(hits[1*CoordBits +: CoordBits]);
    x2 = $signed(hits[2*CoordBits +: CoordBits]);
    y2 = $signed(hits[3*CoordBits +: CoordBits]);
    x3 = $signed(hits[4*CoordBits +: CoordBits]);
    y3 = $signed(hits[5*CoordBits +: CoordBits]);
    det = (x2 - x1) * (y3 - y1) - (y2 - y1) * (x3 - x1);
    r.curvature = '0;
    r.collinear = 1'b0;
    r.saturated = 1'b0;
    if (det == 0) begin
      r.collinear = 1'b1;
      return r;
    end
    dmag = (det < 0) ? -det : det;
    sa = (x2-x1)*(x2-x1) + (y2-y1)*(y2-y1);
    sb = (x3-x2)*(x3-x2) + (y3-y2)*(y3-y2);
    sc = (x1-x3)*(x1-x3) + (y1-y3)*(y1-y3);
    prod = 256'(sa) * 256'(sb) * 256'(sc);
    num2 = 256'(dmag) << NumShift;
    num2 = num2 * num2;
    q = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = 256'(q | (64'd1 << b));
      trial = cand * cand * prod;
      if (trial <= num2) q = q | (64'd1 << b);
    end
    lim = (det > 0) ? 64'h8000_0000 : 64'h7fff_ffff;
    if (q > lim) begin
      q = lim;
      r.saturated = 1'b1;
    end
    r.curvature = (det > 0) ? CurvBits'(-q) : CurvBits'(q);
    return r;
  endfunction

  class curv_scoreboard;
    curv_res_t pending[$];
    int        mismatches;
    int        checked;
    int        n_coll;
    int        n_sat;

    function void note_request(logic [DataBits-1:0] hits);
      curv_res_t r;
      r = menger_curvature(hits);
      if (r.collinear) n_coll++;
      if (r.saturated) n_sat++;
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(logic [CurvBits-1:0] data, logic [1:0] user);
      curv_res_t e;
      if (pending.size() == 0) begin
        $error("result with no request outstanding: curvature %0h", data);
        mismatches++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (data !== e.curvature) begin
        $error("curvature: expected %0d, got %0d", $signed(e.curvature), $signed(data));
        mismatches++;
      end
      if (user[CollBit] !== e.collinear) begin
        $error("collinear: expected %0b, got %0b", e.collinear, user[CollBit]);
        mismatches++;
      end
      if (user[SatBit] !== e.saturated) begin
        $error("saturated: expected %0b, got %0b", e.saturated, user[SatBit]);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [DataBits-1:0] s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [CurvBits-1:0] m_axis_tdata_o;
  logic [1:0]          m_axis_tuser_o;

  int send_idle_pct;
  int recv_stall_pct;
  int n_sent;
  curv_scoreboard sb = new();

  three_point_curvature i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) sb.note_request(s_axis_tdata_i);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [DataBits-1:0] pack_hits(longint x1, longint y1, longint x2,
                                                    longint y2, longint x3, longint y3);
    logic [DataBits-1:0] d;
    d = '0;
    d[0*CoordBits +: CoordBits] = x1[CoordBits-1:0];
    d[1*CoordBits +: CoordBits] = y1[CoordBits-1:0];
    d[2*CoordBits +: CoordBits] = x2[CoordBits-1:0];
    d[3*CoordBits +: CoordBits] = y2[CoordBits-1:0];
    d[4*CoordBits +: CoordBits] = x3[CoordBits-1:0];
    d[5*CoordBits +: CoordBits] = y3[CoordBits-1:0];
    return d;
  endfunction

  function automatic longint rnd_range(longint lo, longint hi);
    return lo + longint'($urandom_range(32'(hi - lo)));
  endfunction

  task automatic send_request(logic [DataBits-1:0] hits);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= hits;
    do @(posedge clk_i); while (!s_axis_tready_o);
    n_sent++;
  endtask

  task automatic send_random;
    longint x1, y1, x2, y2, x3, y3, dx, dy, k, rad;
    int kind;
    kind = $urandom_range(99);
    x1 = rnd_range(CoordMin, CoordMax);
    y1 = rnd_range(CoordMin, CoordMax);
    if (kind < 50) begin
      case ($urandom_range(3))
        0: rad = 4;
        1: rad = 64;
        2: rad = 4096;
        default: rad = 200000;
      endcase
      x1 = rnd_range(CoordMin + rad, CoordMax - rad);
      y1 = rnd_range(CoordMin + rad, CoordMax - rad);
      x2 = x1 + rnd_range(-rad, rad);
      y2 = y1 + rnd_range(-rad, rad);
      x3 = x1 + rnd_range(-rad, rad);
      y3 = y1 + rnd_range(-rad, rad);
    end else if (kind < 75) begin
      x2 = rnd_range(CoordMin, CoordMax);
      y2 = rnd_range(CoordMin, CoordMax);
      x3 = rnd_range(CoordMin, CoordMax);
      y3 = rnd_range(CoordMin, CoordMax);
    end else if (kind < 90) begin
      x1 = rnd_range(-200000, 200000);
      y1 = rnd_range(-200000, 200000);
      dx = rnd_range(-1000, 1000);
      dy = rnd_range(-1000, 1000);
      k  = rnd_range(-300, 300);
      x2 = x1 + dx;
      y2 = y1 + dy;
      x3 = x1 + k * dx;
      y3 = y1 + k * dy;
    end else begin
      x2 = rnd_range(CoordMin, CoordMax);
      y2 = rnd_range(CoordMin, CoordMax);
      case ($urandom_range(2))
        0: begin x3 = x1; y3 = y1; end
        1: begin x3 = x2; y3 = y2; end
        default: begin x2 = x1; y2 = y1; x3 = x1; y3 = y1; end
      endcase
    end
    send_request(pack_hits(x1, y1, x2, y2, x3, y3));
  endtask

  task automatic wait_drained;
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    #2ms;
    $display("three_point_curvature verification failed");
    $finish;
  end

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    send_request(pack_hits(0, 0, 0, 0, 0, 0));
    send_request(pack_hits(0, 0, 1, 1, 2, 2));
    send_request(pack_hits(0, 0, 1, 0, 0, 1));
    send_request(pack_hits(0, 0, 0, 1, 1, 0));
    send_request(pack_hits(0, 0, 4000, 0, 0, 4000));
    send_request(pack_hits(0, 0, 0, 4000, 4000, 0));
    send_request(pack_hits(CoordMin, CoordMin, CoordMax, CoordMin, CoordMin, CoordMax));
    send_request(pack_hits(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMin));
    send_request(pack_hits(CoordMax, CoordMax, CoordMin, CoordMin, CoordMax, CoordMin));
    send_request(pack_hits(CoordMin, CoordMax, CoordMax, CoordMin, 0, 0));
    send_request(pack_hits(CoordMin, CoordMin, CoordMax, CoordMax, CoordMin, CoordMin));
    send_request(pack_hits(CoordMax, CoordMax, CoordMax, CoordMax, CoordMin, CoordMin));
    send_request(pack_hits(-1, -1, -1, -1, -1, -1));
    send_request(pack_hits(CoordMin, 0, CoordMax, 1, CoordMin, 1));
    send_request(pack_hits(CoordMin, 0, CoordMax, 0, 0, 1));
    send_request(pack_hits(CoordMin, 0, CoordMax, 0, 0, -1));
    send_request(pack_hits(100, 200, 300, 700, 500, 1200));
    send_request(pack_hits(3, -7, 5, 11, -13, 2));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      repeat (PhaseLen) send_random();
      if (ph == 1) wait_drained();
    end
    s_axis_tvalid_i <= 1'b0;
    recv_stall_pct = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);

    $display("requests %0d, results checked %0d, collinear %0d, saturated %0d",
             n_sent, sb.checked, sb.n_coll, sb.n_sat);
    $display("gap and stall phases: none, sender only, receiver only, both");
    if (sb.mismatches == 0) begin
      $display("three_point_curvature verification clean");
    end else begin
      $display("three_point_curvature verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/tpc_pkg.sv
design/tpc_mul.sv
design/tpc_div.sv
design/tpc_sqrt.sv
design/three_point_curvature.sv
tb/sv/tb_top.sv
